// ===== hdl/assert_macros.svh =====
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_HOLDS(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

// ===== hdl/cwlc_pkg.sv =====
`default_nettype none
package cwlc_pkg;

    // default sizing
    localparam int MAX_VERTICES_DEF    = 8;
    localparam int T_FRACTION_BITS_DEF = 16;

    // command codes carried in tuser
    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_CLIP  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_DEGENERATE = 2'd0;
    localparam logic [1:0] ST_REJECTED   = 2'd1;
    localparam logic [1:0] ST_CLIPPED    = 2'd2;
    localparam logic [1:0] ST_STORED     = 2'd3;

    localparam logic [3:0] VCOUNT_RESET = 4'd4;
    localparam logic [3:0] VCOUNT_MIN   = 4'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_RD1,
        S_PREP,
        S_MUL,
        S_EVAL,
        S_DIV,
        S_UPD,
        S_FIN,
        S_INTERP
    } t_state;

endpackage
`default_nettype wire

// ===== hdl/convex_window_line_clipper.sv =====
`default_nettype none
// Cyrus-Beck clipper of a 2D integer segment against a convex, counterclockwise
// window of up to MAX_VERTICES vertices. tuser=0 stores one window vertex and
// returns status "stored"; tuser=1 clips a segment. A degenerate segment is
// answered from the idle state. A clip otherwise walks the edges one at a
// time: two vertex reads, four products on one shared 18-bit multiplier, and a
// restoring divider that makes one bit of t per cycle; an edge that is parallel
// or whose t falls outside 0..1 skips the divider. The end points come out of
// the same multiplier in Q16.8. The block takes no new item until the result
// has been transferred. The vertex count register may be written only while
// the block is idle; vertices never stored read as junk.
`include "assert_macros.svh"
module convex_window_line_clipper
    import cwlc_pkg::*;
#(
    parameter int MAX_VERTICES    = MAX_VERTICES_DEF,
    parameter int T_FRACTION_BITS = T_FRACTION_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // tdata: vertex_index, vertex_x, vertex_y, start_x, start_y, end_x, end_y
    input  wire logic [103:0] s_axis_tdata,
    // tuser: command
    input  wire logic         s_axis_tuser,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y
    output logic [95:0]       m_axis_tdata,
    // tuser: status
    output logic [1:0]        m_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [3:0]   i_cfg_data
);

    localparam int AW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW   = (AW + 1 > 4) ? AW + 1 : 4;
    localparam int TF   = T_FRACTION_BITS;
    localparam int TW   = TF + 1;
    localparam int BW   = (TW + 1 > 18) ? TW + 1 : 18;
    localparam int PW   = 18 + BW;
    localparam int W    = 37;
    localparam int RW   = W + 1;
    localparam int QW   = $clog2(TW + 1);
    localparam int SH   = TF - 8;
    localparam logic [PW:0]   HALF   = (SH == 0) ? '0 : (PW+1)'(1) << (SH - 1);
    localparam logic [TW-1:0] T_ONE  = TW'(1) << TF;
    localparam logic [CW-1:0] MAX_C  = CW'(MAX_VERTICES);

    // input fields
    logic [2:0]         in_idx;
    logic signed [15:0] in_vx, in_vy, in_sx, in_sy, in_ex, in_ey;
    assign in_idx = s_axis_tdata[2:0];
    assign in_vx  = s_axis_tdata[18:3];
    assign in_vy  = s_axis_tdata[34:19];
    assign in_sx  = s_axis_tdata[50:35];
    assign in_sy  = s_axis_tdata[66:51];
    assign in_ex  = s_axis_tdata[82:67];
    assign in_ey  = s_axis_tdata[98:83];

    t_state r_state, n_state;

    logic [3:0]          r_vcount;
    logic [CW-1:0]       n_edges;
    logic [AW-1:0]       r_edge, edge_next;
    logic                last_edge;
    logic signed [15:0]  r_p1x, r_p1y;
    logic signed [16:0]  r_dx, r_dy;
    logic signed [15:0]  r_bx, r_by;
    logic signed [15:0]  r_rd_x, r_rd_y;
    logic signed [16:0]  r_ex, r_ey, r_px, r_py;
    logic [2:0]          r_step;
    logic signed [PW-1:0] r_prod;
    logic signed [W-1:0] r_acc, r_den, r_num;
    logic signed [W-1:0] an, ad;
    logic [RW-1:0]       r_rem;
    logic [W-1:0]        r_ad;
    logic [TW-1:0]       r_q;
    logic [QW-1:0]       r_cnt;
    logic                r_den_neg;
    logic [TW-1:0]       r_te, r_tl;
    logic                r_out_valid;
    logic [1:0]          r_out_status;
    logic [95:0]         r_out_data;
    logic                in_acc;
    logic                eval_skip;

    logic signed [15:0]  mem_x [MAX_VERTICES];
    logic signed [15:0]  mem_y [MAX_VERTICES];
    logic [AW-1:0]       rd_addr;

    // clamped edge count and edge stepping
    always_comb begin
        if (r_vcount < VCOUNT_MIN) begin
            n_edges = CW'(VCOUNT_MIN);
        end else if (CW'(r_vcount) > MAX_C) begin
            n_edges = MAX_C;
        end else begin
            n_edges = CW'(r_vcount);
        end
        last_edge = (CW'(r_edge) + CW'(1)) >= n_edges;
        edge_next = last_edge ? '0 : AW'(CW'(r_edge) + CW'(1));
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_out_valid;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= VCOUNT_RESET;
        end else if (i_cfg_valid) begin
            r_vcount <= i_cfg_data;
        end
    end

    // vertex store, one write and one registered read per cycle
    assign rd_addr = (r_state == S_RD0) ? r_edge : edge_next;
    always_ff @(posedge i_clk) begin
        if (in_acc && s_axis_tuser == CMD_STORE && CW'(in_idx) < MAX_C) begin
            mem_x[AW'(in_idx)] <= in_vx;
            mem_y[AW'(in_idx)] <= in_vy;
        end
        r_rd_x <= mem_x[rd_addr];
        r_rd_y <= mem_y[rd_addr];
    end

    // edge test on the freshly formed numerator and denominator
    always_comb begin
        an        = r_den[W-1] ? -r_num : r_num;
        ad        = r_den[W-1] ? -r_den : r_den;
        eval_skip = (r_den == '0) || an[W-1] || (an > ad);
    end

    // shared multiplier operands
    logic signed [17:0]   mul_a;
    logic signed [BW-1:0] mul_b;
    logic [16:0]          adx, ady;
    assign adx = r_dx[16] ? 17'(-r_dx) : 17'(r_dx);
    assign ady = r_dy[16] ? 17'(-r_dy) : 17'(r_dy);
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_MUL) begin
            case (r_step[1:0])
                2'd0: begin mul_a = 18'(r_ey); mul_b = BW'(r_dx); end
                2'd1: begin mul_a = 18'(r_ex); mul_b = BW'(r_dy); end
                2'd2: begin mul_a = 18'(r_ex); mul_b = BW'(r_py); end
                default: begin mul_a = 18'(r_ey); mul_b = BW'(r_px); end
            endcase
        end else begin
            case (r_step[1:0])
                2'd0: begin mul_a = {1'b0, adx}; mul_b = BW'(r_te); end
                2'd1: begin mul_a = {1'b0, ady}; mul_b = BW'(r_te); end
                2'd2: begin mul_a = {1'b0, adx}; mul_b = BW'(r_tl); end
                default: begin mul_a = {1'b0, ady}; mul_b = BW'(r_tl); end
            endcase
        end
    end

    // rounding of the previous product into a Q16.8 point coordinate
    logic [PW:0]        rnd_sum, rnd_sh;
    logic [31:0]        rnd_off;
    logic               coord_y;
    logic signed [31:0] pt_base, pt_val;
    always_comb begin
        rnd_sum = {1'b0, r_prod} + HALF;
        rnd_sh  = rnd_sum >> SH;
        rnd_off = 32'(rnd_sh);
        coord_y = !r_step[0];
        pt_base = coord_y ? (32'(r_p1y) <<< 8) : (32'(r_p1x) <<< 8);
        if (coord_y ? r_dy[16] : r_dx[16]) begin
            pt_val = pt_base - signed'(rnd_off);
        end else begin
            pt_val = pt_base + signed'(rnd_off);
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && s_axis_tuser == CMD_CLIP &&
                    (in_sx != in_ex || in_sy != in_ey)) begin
                    n_state = S_RD0;
                end
            end
            S_RD0:  n_state = S_RD1;
            S_RD1:  n_state = S_PREP;
            S_PREP: n_state = S_MUL;
            S_MUL: begin
                if (r_step == 3'd4) n_state = S_EVAL;
            end
            S_EVAL: begin
                if (!eval_skip) begin
                    n_state = S_DIV;
                end else begin
                    n_state = last_edge ? S_FIN : S_RD0;
                end
            end
            S_DIV: begin
                if (r_cnt == '0) n_state = S_UPD;
            end
            S_UPD:  n_state = last_edge ? S_FIN : S_RD0;
            S_FIN:  n_state = (r_te > r_tl) ? S_IDLE : S_INTERP;
            S_INTERP: begin
                if (r_step == 3'd4) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output handshake control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && (s_axis_tuser == CMD_STORE ||
                                (in_sx == in_ex && in_sy == in_ey))) begin
            r_out_valid <= 1'b1;
        end else if ((r_state == S_FIN && r_te > r_tl) ||
                     (r_state == S_INTERP && r_step == 3'd4)) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= PW'(mul_a * mul_b);
        unique case (r_state)
            S_IDLE: begin
                r_step <= '0;
                r_edge <= '0;
                r_te   <= '0;
                r_tl   <= T_ONE;
                r_p1x  <= in_sx;
                r_p1y  <= in_sy;
                r_dx   <= 17'(in_ex) - 17'(in_sx);
                r_dy   <= 17'(in_ey) - 17'(in_sy);
                if (in_acc) begin
                    if (s_axis_tuser == CMD_STORE) begin
                        r_out_status <= ST_STORED;
                        r_out_data   <= '0;
                    end else begin
                        r_out_status <= ST_DEGENERATE;
                        r_out_data   <= {in_ey, 8'h00, in_ex, 8'h00,
                                         in_sy, 8'h00, in_sx, 8'h00};
                    end
                end
            end
            S_RD0: ;
            S_RD1: begin
                r_bx <= r_rd_x;
                r_by <= r_rd_y;
            end
            S_PREP: begin
                r_ex   <= 17'(r_rd_x) - 17'(r_bx);
                r_ey   <= 17'(r_rd_y) - 17'(r_by);
                r_px   <= 17'(r_p1x) - 17'(r_bx);
                r_py   <= 17'(r_p1y) - 17'(r_by);
                r_step <= '0;
            end
            S_MUL: begin
                r_step <= r_step + 3'd1;
                case (r_step)
                    3'd1: r_acc <= W'(r_prod);
                    3'd2: r_den <= r_acc - W'(r_prod);
                    3'd3: r_acc <= W'(r_prod);
                    3'd4: r_num <= r_acc - W'(r_prod);
                    default: ;
                endcase
            end
            S_EVAL: begin
                r_rem     <= RW'(unsigned'(an));
                r_ad      <= unsigned'(ad);
                r_den_neg <= r_den[W-1];
                r_cnt     <= QW'(TW - 1);
                if (eval_skip) r_edge <= edge_next;
            end
            S_DIV: begin
                // one quotient bit of |num| * 2^TF / |den| per cycle
                if (r_rem >= {1'b0, r_ad}) begin
                    r_rem <= (r_rem - {1'b0, r_ad}) << 1;
                    r_q   <= {r_q[TW-2:0], 1'b1};
                end else begin
                    r_rem <= r_rem << 1;
                    r_q   <= {r_q[TW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - QW'(1);
            end
            S_UPD: begin
                if (r_den_neg) begin
                    if (r_te < r_q) r_te <= r_q;
                end else begin
                    if (r_tl > r_q) r_tl <= r_q;
                end
                r_edge <= edge_next;
            end
            S_FIN: begin
                r_step <= '0;
                if (r_te > r_tl) begin
                    r_out_status <= ST_REJECTED;
                    r_out_data   <= '0;
                end else begin
                    r_out_status <= ST_CLIPPED;
                end
            end
            S_INTERP: begin
                r_step <= r_step + 3'd1;
                case (r_step)
                    3'd1: r_out_data[23:0]  <= pt_val[23:0];
                    3'd2: r_out_data[47:24] <= pt_val[23:0];
                    3'd3: r_out_data[71:48] <= pt_val[23:0];
                    3'd4: r_out_data[95:72] <= pt_val[23:0];
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = r_out_data;

    // checks
    logic t_bad, rem_bad, walk_done;
    assign t_bad     = (r_state != S_IDLE) && (r_te > T_ONE || r_tl > T_ONE);
    assign rem_bad   = (r_state == S_DIV) && (r_rem >= {r_ad, 1'b0});
    assign walk_done = (r_state == S_UPD) && last_edge;
    `ASSERT_NEVER(a_t_range, i_clk, i_rst_n, t_bad, "t out of range")
    `ASSERT_NEVER(a_div_rem, i_clk, i_rst_n, rem_bad, "divider remainder overflow")
    `ASSERT_NEVER(a_busy_out, i_clk, i_rst_n, r_out_valid && (r_state != S_IDLE), "busy")
    `ASSERT_HOLDS(a_fin_next, i_clk, i_rst_n, walk_done |=> (r_state == S_FIN), "edge walk")

endmodule
`default_nettype wire
